[hdl/hta_pkg.sv]
package hta_pkg;

  // Width of the area result in square millimetres.
  localparam int AREA_W = 62;

  // Multiplier digit width: each multiplier stage takes this many bits of one operand.
  localparam int MUL_DIG = 8;

  typedef struct packed {
    logic zero;
    logic neg;
  } hta_flags_t;

endpackage

[hdl/hta_sqrt.sv]
module hta_sqrt #(
  parameter int RAD_W  = 96,
  parameter int ROOT_W = (RAD_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [RAD_W-1:0]  rad,
  output logic              out_v,
  output logic [ROOT_W-1:0] root
);
  import hta_pkg::*;

  localparam int PAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              v_r    [ROOT_W];
  logic [PAD_W-1:0]  rest_r [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  // One result bit per stage: two radicand bits are brought down into the
  // partial remainder and compared with the trial value 4*root + 1.
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic              v_i;
    logic [PAD_W-1:0]  rest_i;
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [REM_W-1:0]  cat;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign v_i    = in_v;
      assign rest_i = PAD_W'(rad);
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rest_i = rest_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
    end

    assign cat   = {rem_i[REM_W-3:0], rest_i[PAD_W-1 -: 2]};
    assign trial = REM_W'({root_i, 2'b01});
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rest_r[s] <= rest_i << 2;
        rem_r[s]  <= ge ? (cat - trial) : cat;
        root_r[s] <= {root_i[ROOT_W-2:0], ge};
      end
    end
  end

  assign out_v = v_r[ROOT_W-1];
  assign root  = root_r[ROOT_W-1];

endmodule

[hdl/hta_mul.sv]
module hta_mul #(
  parameter int A_W  = 50,
  parameter int B_W  = 50,
  parameter int SB_W = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  input  logic [SB_W-1:0]      sb_in,
  output logic                 out_v,
  output logic [A_W+B_W-1:0]   prod,
  output logic [SB_W-1:0]      sb_out
);
  import hta_pkg::*;

  localparam int NST = (B_W + MUL_DIG - 1) / MUL_DIG;
  localparam int BP_W = NST * MUL_DIG;
  localparam int P_W = A_W + BP_W;

  logic            v_r   [NST];
  logic [A_W-1:0]  a_r   [NST];
  logic [BP_W-1:0] b_r   [NST];
  logic [P_W-1:0]  acc_r [NST];
  logic [SB_W-1:0] sb_r  [NST];

  // Each stage adds one digit's partial product into the accumulator.
  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                   v_i;
    logic [A_W-1:0]         a_i;
    logic [BP_W-1:0]        b_i;
    logic [P_W-1:0]         acc_i;
    logic [SB_W-1:0]        sb_i;
    logic [A_W+MUL_DIG-1:0] pp;

    if (s == 0) begin : g_first
      assign v_i   = in_v;
      assign a_i   = a;
      assign b_i   = BP_W'(b);
      assign acc_i = '0;
      assign sb_i  = sb_in;
    end else begin : g_next
      assign v_i   = v_r[s-1];
      assign a_i   = a_r[s-1];
      assign b_i   = b_r[s-1];
      assign acc_i = acc_r[s-1];
      assign sb_i  = sb_r[s-1];
    end

    assign pp = (A_W+MUL_DIG)'(a_i) * (A_W+MUL_DIG)'(b_i[MUL_DIG-1:0]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[s]   <= a_i;
        b_r[s]   <= b_i >> MUL_DIG;
        acc_r[s] <= acc_i + (P_W'(pp) << (MUL_DIG * s));
        sb_r[s]  <= sb_i;
      end
    end
  end

  assign out_v  = v_r[NST-1];
  assign prod   = acc_r[NST-1][A_W+B_W-1:0];
  assign sb_out = sb_r[NST-1];

endmodule

[hdl/hta_lane.sv]
module hta_lane #(
  parameter int COORD_BITS = 31,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_v,
  input  logic signed [COORD_BITS-1:0]       xa,
  input  logic signed [COORD_BITS-1:0]       ya,
  input  logic signed [COORD_BITS-1:0]       xb,
  input  logic signed [COORD_BITS-1:0]       yb,
  output logic                               out_v,
  output logic [COORD_BITS+FRAC_BITS:0]      side
);
  import hta_pkg::*;

  localparam int C = COORD_BITS;
  localparam int RAD_W = 2 * C + 1 + 2 * FRAC_BITS;

  logic [C:0]       ddx, ddy, ndx, ndy;
  logic [C-1:0]     dx_nxt, dy_nxt, dx_r, dy_r;
  logic [2*C-1:0]   sqx_r, sqy_r;
  logic [2*C:0]     sum_r;
  logic             v1_r, v2_r, v3_r;

  assign ddx = {xa[C-1], xa} - {xb[C-1], xb};
  assign ddy = {ya[C-1], ya} - {yb[C-1], yb};
  assign ndx = -ddx;
  assign ndy = -ddy;
  assign dx_nxt = ddx[C] ? ndx[C-1:0] : ddx[C-1:0];
  assign dy_nxt = ddy[C] ? ndy[C-1:0] : ddy[C-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sqx_r <= (2*C)'(dx_r) * (2*C)'(dx_r);
      sqy_r <= (2*C)'(dy_r) * (2*C)'(dy_r);
      sum_r <= (2*C+1)'(sqx_r) + (2*C+1)'(sqy_r);
    end
  end

  hta_sqrt #(
    .RAD_W (RAD_W),
    .ROOT_W(C + FRAC_BITS + 1)
  ) u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (en),
    .in_v (v3_r),
    .rad  (RAD_W'(sum_r) << (2 * FRAC_BITS)),
    .out_v(out_v),
    .root (side)
  );

endmodule

[hdl/hta_merge.sv]
module hta_merge #(
  parameter int COORD_BITS = 31,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [COORD_BITS+FRAC_BITS:0] side_a,
  input  logic [COORD_BITS+FRAC_BITS:0] side_b,
  input  logic [COORD_BITS+FRAC_BITS:0] side_c,
  output logic                          out_v,
  output logic [hta_pkg::AREA_W-1:0]    area
);
  import hta_pkg::*;

  localparam int S_W = COORD_BITS + FRAC_BITS + 1;
  localparam int P_W = S_W + 2;
  localparam int SHIFT = 4 * FRAC_BITS + 4;
  localparam int RAD_W = 4 * P_W - SHIFT;
  localparam int ROOT_W = (RAD_W + 1) / 2;

  logic             v1_r, v2_r, v3_r, v4_r;
  logic [P_W-1:0]   p1_r, p2_r;
  logic [S_W-1:0]   s_r [3];
  logic [P_W-1:0]   mag_nxt [3];
  logic [P_W-1:0]   mag_r [3];
  logic             ltw [3];
  hta_flags_t       fl_nxt, fl_r;

  always_comb begin
    logic [P_W-1:0] twice;
    fl_nxt.zero = (p1_r == '0);
    fl_nxt.neg  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      twice      = P_W'({s_r[i], 1'b0});
      ltw[i]     = (p1_r < twice);
      mag_nxt[i] = ltw[i] ? (twice - p1_r) : (p1_r - twice);
      // An odd number of negative factors makes the whole product negative.
      fl_nxt.neg  = fl_nxt.neg ^ ltw[i];
      fl_nxt.zero = fl_nxt.zero | (mag_nxt[i] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= P_W'(side_a) + P_W'(side_b) + P_W'(side_c);
      s_r[0] <= side_a;
      s_r[1] <= side_b;
      s_r[2] <= side_c;
      p2_r   <= p1_r;
      mag_r  <= mag_nxt;
      fl_r   <= fl_nxt;
    end
  end

  logic                   m1_v, m2_v, m3_v;
  logic [2*P_W-1:0]       m1_p;
  logic [3*P_W-1:0]       m2_p;
  logic [4*P_W-1:0]       m3_p;
  logic [2*P_W+1:0]       m1_sb;
  logic [P_W+1:0]         m2_sb;
  logic [1:0]             m3_sb;
  hta_flags_t             fl3;

  hta_mul #(.A_W(P_W), .B_W(P_W), .SB_W(2*P_W+2)) u_mul1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v2_r),
    .a(p2_r), .b(mag_r[0]), .sb_in({mag_r[1], mag_r[2], fl_r}),
    .out_v(m1_v), .prod(m1_p), .sb_out(m1_sb)
  );

  hta_mul #(.A_W(2*P_W), .B_W(P_W), .SB_W(P_W+2)) u_mul2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(m1_v),
    .a(m1_p), .b(m1_sb[2*P_W+1:P_W+2]), .sb_in(m1_sb[P_W+1:0]),
    .out_v(m2_v), .prod(m2_p), .sb_out(m2_sb)
  );

  hta_mul #(.A_W(3*P_W), .B_W(P_W), .SB_W(2)) u_mul3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(m2_v),
    .a(m2_p), .b(m2_sb[P_W+1:2]), .sb_in(m2_sb[1:0]),
    .out_v(m3_v), .prod(m3_p), .sb_out(m3_sb)
  );

  assign fl3 = hta_flags_t'(m3_sb);

  logic [4*P_W-1:0]  shifted;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W-1:0] root;
  logic [AREA_W-1:0] area_nxt, area_r;

  assign shifted = m3_p >> SHIFT;

  // A zero or negative radicand gives a zero area; sqrt(0) is 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= (fl3.zero || fl3.neg) ? '0 : shifted[RAD_W-1:0];
    end
  end

  logic sq_v;

  hta_sqrt #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v3_r),
    .rad(rad_r), .out_v(sq_v), .root(root)
  );

  if (ROOT_W > AREA_W) begin : g_sat
    assign area_nxt = (root[ROOT_W-1:AREA_W] != '0) ? '1 : root[AREA_W-1:0];
  end else begin : g_nosat
    assign area_nxt = AREA_W'(root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      area_r <= area_nxt;
    end
  end

  assign out_v = v4_r;
  assign area  = area_r;

endmodule

[hdl/heron_triangle_area.sv]
// Triangle area by Heron's formula. Each item carries three points with signed
// millimetre coordinates; the result is the area in whole square millimetres,
// truncated. Three lanes compute the side lengths in parallel (abs difference,
// squaring, summing, then a pipelined square root with one result bit per
// stage), and a merge stage forms the perimeter, the product
// p(p-2a)(p-2b)(p-2c) through three pipelined multipliers that take 8 bits of
// one operand per stage, and a final pipelined square root. One item is
// accepted per cycle while in_stall is low. A two-entry output buffer lets
// the pipeline keep taking items while one result waits; in_stall rises
// only when both are full.
module heron_triangle_area #(
  parameter int COORD_BITS = 31,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_first_x,
  input  logic signed [COORD_BITS-1:0]       in_first_y,
  input  logic signed [COORD_BITS-1:0]       in_second_x,
  input  logic signed [COORD_BITS-1:0]       in_second_y,
  input  logic signed [COORD_BITS-1:0]       in_third_x,
  input  logic signed [COORD_BITS-1:0]       in_third_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hta_pkg::AREA_W-1:0]         out_area_sq_mm
);
  import hta_pkg::*;

  localparam int S_W = COORD_BITS + FRAC_BITS + 1;

  logic              adv;
  logic              lv0, lv1, lv2;
  logic [S_W-1:0]    sa, sb, sc;
  logic              pipe_v;
  logic [AREA_W-1:0] pipe_area;

  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [AREA_W-1:0] out_r, out_nxt, skid_r, skid_nxt;

  assign adv = !skid_v_r;
  assign in_stall = skid_v_r;

  hta_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane0 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(in_valid),
    .xa(in_first_x), .ya(in_first_y), .xb(in_second_x), .yb(in_second_y),
    .out_v(lv0), .side(sa)
  );

  hta_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(in_valid),
    .xa(in_second_x), .ya(in_second_y), .xb(in_third_x), .yb(in_third_y),
    .out_v(lv1), .side(sb)
  );

  hta_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(in_valid),
    .xa(in_third_x), .ya(in_third_y), .xb(in_first_x), .yb(in_first_y),
    .out_v(lv2), .side(sc)
  );

  hta_merge #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_v(lv0 & lv1 & lv2),
    .side_a(sa), .side_b(sb), .side_c(sc),
    .out_v(pipe_v), .area(pipe_area)
  );

  // The pipeline is frozen while the skid entry is full.
  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (!out_stall) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_v) begin
      if (out_v_r && out_stall) begin
        skid_v_nxt = 1'b1;
        skid_nxt   = pipe_area;
      end else begin
        out_v_nxt = 1'b1;
        out_nxt   = pipe_area;
      end
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_area_sq_mm = out_r;

  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && out_stall))
    else $error("skid entry filled without a stalled result");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_stall |=> skid_v_r && $stable(skid_r))
    else $error("skid entry lost while output stalled");

endmodule
